### sv/uarttx_pkg.sv
// ----------------------------------------------------------------------------
// uarttx_pkg
// Types and constants shared by the 8N1 serial transmitter and its testbench.
// ----------------------------------------------------------------------------
package uarttx_pkg;

  // Request command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ENQ  = 1'b1;

  // Frame geometry
  localparam logic [3:0] DATA_BITS = 4'd8;

  localparam int unsigned TPB_W = 16;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic byte_dropped;
  } res_t;

endpackage

### sv/serial_8n1_transmitter_with_fifo.sv
// ----------------------------------------------------------------------------
// serial_8n1_transmitter_with_fifo
// 8N1 asynchronous serial transmitter fed by a ring FIFO held in RAM.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o  | req_t: command, data_byte
//  out     | output    | out_valid_o / out_stall_i| res_t: line_level, busy_res,
//          |           |                         |        byte_dropped
//  cfg     | input     | cfg_we_i                | cfg_wdata_i = ticks_per_bit
//
//  Each result is registered and shown the cycle after acceptance, and a new
//  request is taken each cycle unless a result is held and the output is stalled.
//  The head byte is prefetched from the FIFO RAM every cycle through a registered
//  read, so a frame reload at a stop-bit boundary does not wait on the RAM.
//  Reset clears pointers, transmitter flags and sets ticks_per_bit to 32;
//  the FIFO RAM needs no clearing pass.
//  The input stalls only while a result is held and the output is stalled.
//
module serial_8n1_transmitter_with_fifo #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  uarttx_pkg::req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uarttx_pkg::res_t   out_res_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);

  import uarttx_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // Advance a ring pointer, wrapping at the FIFO depth
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Configuration and state
  logic [TPB_W-1:0] tpb_q;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [PTR_W-1:0] rp_q, rp_d;
  logic             sending_q, sending_d;
  logic [7:0]       shift_q, shift_d;
  logic [3:0]       pos_q, pos_d;
  logic             stop_q, stop_d;
  logic [TPB_W-1:0] cnt_q, cnt_d;
  logic             line_q, line_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  // RAM bypass for a write landing on the entry being prefetched
  logic             byp_q, byp_d;
  logic [7:0]       byp_data_q;

  logic             acc;
  logic             is_enq;
  logic             is_tick;
  logic [PTR_W-1:0] wp_nxt;
  logic             full;
  logic             wr_en;
  logic [7:0]       ram_rdata;
  logic [7:0]       head;
  logic [TPB_W-1:0] bit_time;
  logic [TPB_W-1:0] cnt_dec;
  logic             dropped;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign acc        = in_valid_i & ~in_stall_o;
  assign is_enq     = acc & (in_req_i.command == CMD_ENQ);
  assign is_tick    = acc & (in_req_i.command == CMD_TICK);

  assign wp_nxt   = ring_next(wp_q);
  assign full     = (wp_nxt == rp_q);
  assign wr_en    = is_enq & ~full;
  assign head     = byp_q ? byp_data_q : ram_rdata;
  // A zero bit time behaves as one tick
  assign bit_time = (tpb_q == '0) ? TPB_W'(1) : tpb_q;
  assign cnt_dec  = (cnt_q != '0) ? cnt_q - TPB_W'(1) : cnt_q;

  // FIFO storage; read address follows the next read pointer so the head
  // byte is always ready from the registered read
  uarttx_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wp_q),
    .wdata_i (in_req_i.data_byte),
    .raddr_i (rp_d),
    .rdata_o (ram_rdata)
  );

  // Transmitter and FIFO update
  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    sending_d = sending_q;
    shift_d   = shift_q;
    pos_d     = pos_q;
    stop_d    = stop_q;
    cnt_d     = cnt_q;
    line_d    = line_q;
    dropped   = 1'b0;

    if (is_enq) begin
      if (full) begin
        dropped = 1'b1;
      end else begin
        wp_d = wp_nxt;
      end
      // Idle means the FIFO is empty: take the new byte straight away
      if (!sending_q && !full) begin
        sending_d = 1'b1;
        shift_d   = in_req_i.data_byte;
        rp_d      = ring_next(rp_q);
        pos_d     = '0;
        stop_d    = 1'b0;
        line_d    = 1'b0;
        cnt_d     = bit_time;
      end
    end else if (is_tick && sending_q) begin
      if (cnt_dec == '0) begin
        cnt_d = bit_time;
        priority if (pos_q < DATA_BITS) begin
          line_d = shift_q[pos_q[2:0]];
          pos_d  = pos_q + 4'd1;
        end else if (!stop_q) begin
          line_d = 1'b1;
          stop_d = 1'b1;
        end else if (rp_q != wp_q) begin
          // Reload from the prefetched head of the FIFO
          shift_d = head;
          rp_d    = ring_next(rp_q);
          pos_d   = '0;
          stop_d  = 1'b0;
          line_d  = 1'b0;
        end else begin
          sending_d = 1'b0;
          line_d    = 1'b1;
        end
      end else begin
        cnt_d = cnt_dec;
      end
    end
  end

  assign byp_d = wr_en & (wp_q == rp_d);

  // Output register: load on accept, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (acc) begin
      out_valid_d        = 1'b1;
      res_d.line_level   = line_d;
      res_d.busy_res     = sending_d;
      res_d.byte_dropped = dropped;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q       <= TPB_W'(32);
      wp_q        <= '0;
      rp_q        <= '0;
      sending_q   <= 1'b0;
      shift_q     <= '0;
      pos_q       <= '0;
      stop_q      <= 1'b0;
      cnt_q       <= '0;
      line_q      <= 1'b1;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tpb_q <= cfg_wdata_i;
      end
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      sending_q   <= sending_d;
      shift_q     <= shift_d;
      pos_q       <= pos_d;
      stop_q      <= stop_d;
      cnt_q       <= cnt_d;
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
      byp_q       <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    byp_data_q <= in_req_i.data_byte;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // The line idles high whenever no frame is in progress
  a_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_res_o.busy_res) |-> out_res_o.line_level)
    else $error("line low while transmitter idle");

  // Going idle only happens with an empty FIFO
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (rp_q == wp_q))
    else $error("transmitter idle with bytes queued");

  // Every accepted request produces a result in the next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_o)
    else $error("accepted request produced no result");

  // A drop is only reported for an enqueue
  a_drop_enq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_req_i.command == CMD_TICK) |=> !out_res_o.byte_dropped)
    else $error("drop flagged on a tick request");

endmodule

### sv/uarttx_ram.sv
// ----------------------------------------------------------------------------
// uarttx_ram
// Generic single-write, single-read RAM with a registered read (read-first).
// ----------------------------------------------------------------------------
module uarttx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 8N1 serial transmitter with its byte queue.
// A walked table of directed requests opens the run; random phases with
// varying bit times follow. Typed rows give their own expected result; every
// other is checked against a cycle-free model of line, busy and drop in the bench.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uarttx_pkg::*;

  localparam int unsigned FIFO_DEPTH   = 64;
  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned LONG_HOLD    = 400;        // receiver hold-off, in cycles
  localparam int unsigned RAND_PHASES  = 12;
  localparam int unsigned PHASE_REQS   = 40;         // live requests per random phase
  localparam int unsigned DRAIN_LIMIT  = 10000;
  localparam longint unsigned LIMIT_CYCLES = 2_000_000;

  // Directed table: a row either writes the bit time or issues a request
  // some number of times. Typed rows carry the result to expect.
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic        cmd;
    logic [7:0]  data;
    int unsigned reps;
    bit          typed;
    res_t        want;
    logic [15:0] bit_ticks;
  } plan_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i;
  logic        in_stall_o;
  req_t        in_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  res_t        out_res_o;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  // Results still owed by the block, oldest first
  res_t pending_line_states [$];

  // Idling knobs, shared by the two sides
  bit tx_idle_on    = 1'b1;
  bit rx_idle_on    = 1'b1;
  bit long_hold_req = 1'b0;

  int unsigned n_req     = 0;
  int unsigned n_live    = 0;
  int unsigned n_enq     = 0;
  int unsigned n_drop    = 0;
  int unsigned n_checked = 0;
  int unsigned n_holds   = 0;
  int unsigned n_fail    = 0;

  // Model of the transmitter: queue, pointers and frame state
  logic [7:0]  m_fifo [FIFO_DEPTH];
  int unsigned m_wp, m_rp;
  logic        m_sending, m_stop_sent, m_line;
  logic [7:0]  m_shift;
  logic [3:0]  m_bitpos;
  logic [15:0] m_count;
  logic [15:0] m_bit_ticks;

  serial_8n1_transmitter_with_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  function automatic int unsigned ring_next(input int unsigned p);
    return (p + 1) % FIFO_DEPTH;
  endfunction

  // A bit time of zero behaves as one tick
  function automatic logic [15:0] bit_time();
    return (m_bit_ticks == 16'd0) ? 16'd1 : m_bit_ticks;
  endfunction

  // Pop the head byte into the shifter and drive the start bit low
  function automatic void load_frame();
    m_shift     = m_fifo[m_rp];
    m_rp        = ring_next(m_rp);
    m_bitpos    = 4'd0;
    m_stop_sent = 1'b0;
    m_line      = 1'b0;
  endfunction

  function automatic void tx_model_reset();
    m_bit_ticks = 16'd32;
    m_wp        = 0;
    m_rp        = 0;
    m_sending   = 1'b0;
    m_shift     = 8'h00;
    m_bitpos    = 4'd0;
    m_stop_sent = 1'b0;
    m_count     = 16'd0;
    m_line      = 1'b1;
  endfunction

  // Advance the model by one request and return the result it yields
  function automatic res_t serial_line_step(input logic cmd, input logic [7:0] data);
    res_t        r;
    logic        dropped;
    int unsigned nxt;
    dropped = 1'b0;
    // A tick with the transmitter idle changes nothing; count the rest
    if (cmd == CMD_ENQ || m_sending) n_live++;
    if (cmd == CMD_ENQ) begin
      n_enq++;
      nxt = ring_next(m_wp);
      // One slot always stays empty, so a full ring holds depth - 1 bytes
      if (nxt != m_rp) begin
        m_fifo[m_wp] = data;
        m_wp         = nxt;
      end else begin
        dropped = 1'b1;
        n_drop++;
      end
      // Idle transmitter: start the frame at once
      if (!m_sending && m_rp != m_wp) begin
        m_sending = 1'b1;
        load_frame();
        m_count = bit_time();
      end
    end else if (m_sending) begin
      if (m_count != 16'd0) m_count--;
      // Bit boundary: the bit time in force now sets the next countdown
      if (m_count == 16'd0) begin
        m_count = bit_time();
        if (m_bitpos < DATA_BITS) begin
          m_line = m_shift[m_bitpos[2:0]];
          m_bitpos++;
        end else if (!m_stop_sent) begin
          m_line      = 1'b1;
          m_stop_sent = 1'b1;
        end else if (m_rp != m_wp) begin
          load_frame();
        end else begin
          m_sending = 1'b0;
          m_line    = 1'b1;
        end
      end
    end
    r.line_level   = m_line;
    r.busy_res     = m_sending;
    r.byte_dropped = dropped;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offer one request and hold it until accepted. Valid is only lowered
  // ahead of a gap, so it never falls and rises within one time step.
  task automatic send_req(input logic cmd, input logic [7:0] data,
                          input bit typed, input res_t want);
    res_t        predicted;
    int unsigned g;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      g = idle_len();
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_req_i.command   <= cmd;
    in_req_i.data_byte <= data;
    do @(posedge clk_i); while (in_stall_o);
    // Accepted at this edge: advance the model and queue its result
    predicted = serial_line_step(cmd, data);
    pending_line_states.push_back(typed ? want : predicted);
    n_req++;
  endtask

  // Write the bit time once every owed result has arrived
  task automatic write_bit_time(input logic [15:0] ticks);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_line_states.size() != 0);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    m_bit_ticks  = ticks;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    plan_row_t   plan [$];
    int unsigned ph, k, live_mark;
    bit          enq_heavy;
    logic        cmd;
    logic [15:0] bt;

    plan = '{
      // Tick after reset: line idles high, nothing busy
      '{ROW_REQ, CMD_TICK, 8'h00, 1,     1'b1, 3'b100, 16'h0000},
      // Enqueue into an idle transmitter: start bit goes out at once
      '{ROW_REQ, CMD_ENQ,  8'h00, 1,     1'b1, 3'b010, 16'h0000},
      // Enqueue while busy: queued only, the start bit holds
      '{ROW_REQ, CMD_ENQ,  8'hFF, 1,     1'b1, 3'b010, 16'h0000},
      '{ROW_REQ, CMD_TICK, 8'h00, 40,    1'b0, 3'b000, 16'h0000},
      // Zero bit time written mid bit: running countdown is kept
      '{ROW_CFG, CMD_TICK, 8'h00, 0,     1'b0, 3'b000, 16'h0000},
      '{ROW_REQ, CMD_TICK, 8'h00, 30,    1'b0, 3'b000, 16'h0000},
      // Overfill the ring: the surplus bytes are dropped and flagged
      '{ROW_REQ, CMD_ENQ,  8'hA5, 70,    1'b0, 3'b000, 16'h0000},
      '{ROW_REQ, CMD_TICK, 8'h00, 650,   1'b0, 3'b000, 16'h0000},
      '{ROW_CFG, CMD_TICK, 8'h00, 0,     1'b0, 3'b000, 16'h0001},
      '{ROW_REQ, CMD_ENQ,  8'h01, 1,     1'b0, 3'b000, 16'h0000},
      '{ROW_REQ, CMD_ENQ,  8'h80, 1,     1'b0, 3'b000, 16'h0000},
      '{ROW_REQ, CMD_TICK, 8'hFF, 40,    1'b0, 3'b000, 16'h0000},
      // Long bit time: one start bit of 100 ticks
      '{ROW_CFG, CMD_TICK, 8'h00, 0,     1'b0, 3'b000, 16'h0064},
      '{ROW_REQ, CMD_ENQ,  8'h01, 1,     1'b0, 3'b000, 16'h0000},
      '{ROW_REQ, CMD_TICK, 8'h00, 5,     1'b0, 3'b000, 16'h0000},
      // Shorten it mid bit: the long countdown runs out before 3 applies
      '{ROW_CFG, CMD_TICK, 8'h00, 0,     1'b0, 3'b000, 16'h0003},
      '{ROW_REQ, CMD_TICK, 8'h00, 130,   1'b0, 3'b000, 16'h0000},
      '{ROW_REQ, CMD_ENQ,  8'h7E, 1,     1'b0, 3'b000, 16'h0000},
      '{ROW_REQ, CMD_ENQ,  8'h81, 1,     1'b0, 3'b000, 16'h0000},
      '{ROW_REQ, CMD_TICK, 8'h00, 70,    1'b0, 3'b000, 16'h0000}
    };

    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 16'h0000;
    tx_model_reset();

    // Hold reset, then release it on an edge
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table; run the long rows without idling
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_bit_time(plan[i].bit_ticks);
      end else begin
        tx_idle_on = (plan[i].reps < 500);
        rx_idle_on = tx_idle_on;
        repeat (plan[i].reps) send_req(plan[i].cmd, plan[i].data, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: short bit times keep frames moving; each phase either
    // floods the queue with bytes or mostly ticks it empty
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       bt = 16'd1;
        1:       bt = 16'd0;
        2:       bt = 16'd2;
        default: bt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3))
                                                   : 16'($urandom_range(1, 12));
      endcase
      write_bit_time(bt);
      enq_heavy  = (ph == 5) ? 1'b1 : 1'($urandom_range(0, 1));
      tx_idle_on = (ph % 4 != 3);
      rx_idle_on = tx_idle_on;
      live_mark  = n_live;
      k          = 0;
      // Count only requests that do something; idle ticks are free
      while (n_live - live_mark < PHASE_REQS) begin
        // Hold the output off for a long stretch while requests keep coming
        if (ph == 5 && k == 10) begin
          tx_idle_on    = 1'b0;
          long_hold_req = 1'b1;
        end
        if (enq_heavy) cmd = ($urandom_range(0, 9) < 6) ? CMD_ENQ : CMD_TICK;
        else           cmd = ($urandom_range(0, 11) == 0) ? CMD_ENQ : CMD_TICK;
        send_req(cmd, 8'($urandom_range(0, 255)), 1'b0, '0);
        k++;
      end
    end

    // Drop valid, drain the owed results, then check that none is left
    in_valid_i <= 1'b0;
    k = 0;
    while (pending_line_states.size() != 0 && k < DRAIN_LIMIT) begin
      @(posedge clk_i);
      k++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_line_states.size() != 0) begin
      $error("%0d results never arrived", pending_line_states.size());
      n_fail++;
    end

    $display("Run covered %0d requests, %0d enqueues (%0d dropped on a full ring), %0d results.",
             n_req, n_enq, n_drop, n_checked);
    $display("Bit times from 0 to 100 were used, with %0d long output hold-off(s).", n_holds);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : rx_side
    int unsigned g;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        n_holds++;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        g = idle_len();
        out_stall_i <= 1'b1;
        repeat (g) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each accepted result with the oldest owed one
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : line_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_line_states.size() == 0) begin
        $error("result %b with no request outstanding", out_res_o);
        n_fail++;
      end else begin
        want = pending_line_states.pop_front();
        n_checked++;
        if (out_res_o.line_level !== want.line_level) begin
          $error("line_level: expected %0b, got %0b", want.line_level, out_res_o.line_level);
          n_fail++;
        end
        if (out_res_o.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0b, got %0b", want.busy_res, out_res_o.busy_res);
          n_fail++;
        end
        if (out_res_o.byte_dropped !== want.byte_dropped) begin
          $error("byte_dropped: expected %0b, got %0b",
                 want.byte_dropped, out_res_o.byte_dropped);
          n_fail++;
        end
      end
    end
  end

  // Give up after a generous fixed time
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

endmodule

### files.f
sv/uarttx_pkg.sv
sv/uarttx_ram.sv
sv/serial_8n1_transmitter_with_fifo.sv
test/tb.sv
